### rtl/lqf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqf_pkg
// Shared sizes, types and codes for the linked-list queue with free list.
// ----------------------------------------------------------------------------
package lqf_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 8;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [VALUE_W-1:0] value_t;

  // One node link: a clear valid bit marks a null pointer.
  typedef struct packed {
    logic valid;
    idx_t idx;
  } link_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic exec;
    logic front_load;
    logic out_load;
  } lqf_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_front;
  } lqf_stat_t;

endpackage

### rtl/lqf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqf_if
// Valid/ready channels for queue operations and their results.
// ----------------------------------------------------------------------------
interface lqf_in_if import lqf_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   op;
  value_t item_value;

  modport source (output valid, output op, output item_value, input ready);
  modport sink   (input valid, input op, input item_value, output ready);
endinterface

interface lqf_out_if import lqf_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   accepted;
  value_t front_value;
  logic   is_empty;
  logic   is_full;

  modport source (output valid, output accepted, output front_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input accepted, input front_value,
                  input is_empty, input is_full, output ready);
endinterface

### rtl/linked_queue_with_free_list_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linked_queue_with_free_list_top
// Byte FIFO kept as a linked list in a fixed node store with a free list.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                                    Item
// in_ch     in   op, item_value                             enqueue/dequeue
// out_ch    out  accepted, front_value, is_empty, is_full   one per input item
//
// Steps: every item passes accept, execute and result hand-off; a dequeue
// that leaves entries adds a front step between execute and hand-off, which
// takes the value store read of the new front node.
// The registered read port of the link store sets the accept-to-execute step.
// Reset: synchronous; no clearing pass (a fill count stands in for the
// reset links of nodes never taken).
// Stalls: a finished result waits in the output register; the sequencer
// holds in its last step until that register is free.
// ----------------------------------------------------------------------------
module linked_queue_with_free_list_top import lqf_pkg::*; (
  input logic         clk,
  input logic         rst,
  lqf_in_if.sink      in_ch,
  lqf_out_if.source   out_ch
);

  lqf_cmd_t  cmd;
  lqf_stat_t stat;

  // Sequencer: owns the handshakes and the step order.
  lqf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath: stores, pointers and the result register.
  lqf_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .op          (in_ch.op),
    .item_value  (in_ch.item_value),
    .accepted    (out_ch.accepted),
    .front_value (out_ch.front_value),
    .is_empty    (out_ch.is_empty),
    .is_full     (out_ch.is_full)
  );

endmodule

### rtl/lqf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqf_datapath
// Node stores, list pointers, free-node fill count and result register.
// ----------------------------------------------------------------------------
module lqf_datapath import lqf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  lqf_cmd_t  cmd,
  output lqf_stat_t stat,
  input  logic      op,
  input  value_t    item_value,
  output logic      accepted,
  output value_t    front_value,
  output logic      is_empty,
  output logic      is_full
);

  link_t  link_mem [DEPTH];
  value_t value_mem [DEPTH];

  link_t  link_rd;
  value_t value_rd;

  logic   op_q;
  value_t val_q;
  logic   ok;

  idx_t   free_head;
  logic   free_valid;
  idx_t   head_idx;
  logic   head_valid;
  idx_t   tail_idx;
  value_t front;
  // Nodes below this count were never taken; their link is still the reset one.
  cnt_t   fresh;

  idx_t   rd_addr;
  logic   t_fresh;
  link_t  free_next;
  logic   last;

  assign rd_addr = (op == OP_ENQ) ? free_head : head_idx;
  assign t_fresh = cnt_t'(free_head) < fresh;
  assign last    = (head_idx == tail_idx);

  always_comb begin
    if (t_fresh) begin
      free_next.valid = (free_head != '0);
      free_next.idx   = free_head - idx_t'(1);
    end else begin
      free_next = link_rd;
    end
  end

  assign stat.need_front = ok && (op_q == OP_DEQ) && !last;

  // Link store: read on accept, write during execute.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      link_rd <= link_mem[rd_addr];
    end
    if (cmd.exec && ok) begin
      if (op_q == OP_ENQ) begin
        if (head_valid) begin
          link_mem[tail_idx] <= '{valid: 1'b1, idx: free_head};
        end
      end else begin
        link_mem[head_idx] <= '{valid: free_valid, idx: free_head};
      end
    end
  end

  // Value store: write the new node; read at every execute, for the next front on dequeue.
  always_ff @(posedge clk) begin
    if (cmd.exec && ok && op_q == OP_ENQ) begin
      value_mem[free_head] <= val_q;
    end
    if (cmd.exec) begin
      value_rd <= value_mem[link_rd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q  <= op;
      val_q <= item_value;
      ok    <= (op == OP_ENQ) ? free_valid : head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= idx_t'(DEPTH - 1);
      free_valid <= 1'b1;
      head_valid <= 1'b0;
      head_idx   <= '0;
      tail_idx   <= '0;
      fresh      <= cnt_t'(DEPTH);
    end else if (cmd.exec && ok) begin
      if (op_q == OP_ENQ) begin
        free_head  <= free_next.idx;
        free_valid <= free_next.valid;
        tail_idx   <= free_head;
        if (!head_valid) begin
          head_idx   <= free_head;
          head_valid <= 1'b1;
        end
        if (t_fresh) begin
          fresh <= cnt_t'(free_head);
        end
      end else begin
        free_head  <= head_idx;
        free_valid <= 1'b1;
        if (last) begin
          head_valid <= 1'b0;
        end else begin
          head_idx <= link_rd.idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && ok && op_q == OP_ENQ && !head_valid) begin
      front <= val_q;
    end else if (cmd.front_load) begin
      front <= value_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      accepted    <= ok;
      front_value <= head_valid ? front : '0;
      is_empty    <= !head_valid;
      is_full     <= !free_valid;
    end
  end

`ifndef SYNTHESIS
  a_fresh_range: assert property (@(posedge clk) disable iff (rst)
    fresh <= cnt_t'(DEPTH))
    else $error("fill count above depth");
`endif

endmodule

### rtl/lqf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lqf_ctrl
// Sequencer: accept, execute, optional front fetch, hand off the result.
// ----------------------------------------------------------------------------
module lqf_ctrl import lqf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output lqf_cmd_t  cmd,
  input  lqf_stat_t stat
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FRONT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.need_front ? S_FRONT : S_DONE;
      end
      S_FRONT: begin
        cmd.front_load = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        cmd.out_load = slot_free;
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result loaded over a pending one");
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> cmd.exec)
    else $error("accepted item not executed");
  a_front_follow: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && stat.need_front) |=> cmd.front_load)
    else $error("front fetch skipped");
`endif

endmodule
